// File: rtl/core/rrco_pkg.sv
package rrco_pkg;

    // Field widths
    localparam int COORD_WIDTH = 24;
    localparam int ANGLE_WIDTH = 16;
    localparam int EXT_W       = COORD_WIDTH - 1;   // half extents and radius
    localparam int DIFF_W      = COORD_WIDTH + 1;   // circle minus rectangle center

    // Trig values in Q1.15
    localparam int TRIG_W     = 16;
    localparam int TRIG_SHIFT = 15;
    localparam int TRIG_MAX   = 32767;
    localparam int TRIG_HALF  = 16384;

    // Rotation datapath
    localparam int PROD_W = TRIG_W + DIFF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int P_W    = DIFF_W + 2;   // rotated point, signed
    localparam int E_W    = P_W + 1;      // distance past an edge, signed
    localparam int SQ_W   = 2 * EXT_W;

    // CORDIC in Q4.30 with angles in 2^-32 turn
    localparam int CORDIC_W      = 34;
    localparam int CORDIC_STEPS  = 18;
    localparam int CORDIC_STAGES = CORDIC_STEPS / 2;
    localparam int TURN_W        = 32;
    localparam int QUARTER_W     = TURN_W - 2;

    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = CORDIC_W'(652032874);

    localparam logic signed [CORDIC_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        CORDIC_W'(536870912), CORDIC_W'(316933406), CORDIC_W'(167458908),
        CORDIC_W'(85004756),  CORDIC_W'(42667331),  CORDIC_W'(21354465),
        CORDIC_W'(10679838),  CORDIC_W'(5340245),   CORDIC_W'(2670163),
        CORDIC_W'(1335087),   CORDIC_W'(667544),    CORDIC_W'(333772),
        CORDIC_W'(166886),    CORDIC_W'(83443),     CORDIC_W'(41722),
        CORDIC_W'(20861),     CORDIC_W'(10430),     CORDIC_W'(5215)
    };

    // Quadrant of the rotation angle
    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    // Query geometry carried beside the trig pipeline
    typedef struct packed {
        logic signed [DIFF_W-1:0] d0;
        logic signed [DIFF_W-1:0] d1;
        logic [EXT_W-1:0]         hw;
        logic [EXT_W-1:0]         hd;
        logic [EXT_W-1:0]         r;
    } query_t;

    // Rotated point with the extents it is tested against
    typedef struct packed {
        logic signed [P_W-1:0] p0;
        logic signed [P_W-1:0] p1;
        logic [EXT_W-1:0]      hw;
        logic [EXT_W-1:0]      hd;
        logic [EXT_W-1:0]      r;
    } point_t;

endpackage

// File: rtl/core/rrco_cordic.sv
module rrco_cordic (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       en,
    input  logic                                       in_valid,
    input  logic [rrco_pkg::ANGLE_WIDTH-1:0]           heading,
    input  rrco_pkg::query_t                           in_query,
    output logic                                       out_valid,
    output logic signed [rrco_pkg::TRIG_W-1:0]         cos_q15,
    output logic signed [rrco_pkg::TRIG_W-1:0]         sin_q15,
    output rrco_pkg::query_t                           out_query
);

    localparam int CW = rrco_pkg::CORDIC_W;
    localparam int NS = rrco_pkg::CORDIC_STAGES;
    localparam int AW = rrco_pkg::ANGLE_WIDTH;

    logic                  valid_reg [NS];
    logic signed [CW-1:0]  x_reg     [NS];
    logic signed [CW-1:0]  y_reg     [NS];
    logic signed [CW-1:0]  z_reg     [NS];
    rrco_pkg::quad_t       quad_reg  [NS];
    rrco_pkg::query_t      query_reg [NS];

    logic [AW-1:0]         neg_heading;
    logic signed [CW-1:0]  z_init;
    rrco_pkg::quad_t       quad_init;

    // Negate the heading and split it into quadrant and residual angle
    always_comb
    begin
        neg_heading = AW'(0) - heading;
        quad_init   = rrco_pkg::quad_t'(neg_heading[AW-1 -: 2]);
        z_init      = CW'({neg_heading[AW-3:0], {(rrco_pkg::TURN_W - AW){1'b0}}});
    end

    // Two micro-rotations per stage
    for (genvar g = 0; g < NS; g++)
    begin : g_stage
        localparam int S = 2 * g;
        logic                 vi;
        logic signed [CW-1:0] xi, yi, zi, xa, ya, za, xb, yb, zb;
        rrco_pkg::quad_t      qi;
        rrco_pkg::query_t     di;

        if (g == 0)
        begin : g_first
            assign vi = in_valid;
            assign xi = rrco_pkg::CORDIC_X0;
            assign yi = '0;
            assign zi = z_init;
            assign qi = quad_init;
            assign di = in_query;
        end
        else
        begin : g_rest
            assign vi = valid_reg[g-1];
            assign xi = x_reg[g-1];
            assign yi = y_reg[g-1];
            assign zi = z_reg[g-1];
            assign qi = quad_reg[g-1];
            assign di = query_reg[g-1];
        end

        always_comb
        begin
            if (!zi[CW-1])
            begin
                xa = xi - (yi >>> S);
                ya = yi + (xi >>> S);
                za = zi - rrco_pkg::ATAN_TURNS[S];
            end
            else
            begin
                xa = xi + (yi >>> S);
                ya = yi - (xi >>> S);
                za = zi + rrco_pkg::ATAN_TURNS[S];
            end
            if (!za[CW-1])
            begin
                xb = xa - (ya >>> (S + 1));
                yb = ya + (xa >>> (S + 1));
                zb = za - rrco_pkg::ATAN_TURNS[S+1];
            end
            else
            begin
                xb = xa + (ya >>> (S + 1));
                yb = ya - (xa >>> (S + 1));
                zb = za + rrco_pkg::ATAN_TURNS[S+1];
            end
        end

        // Advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g] <= vi;
            end
        end

        // Advance the rotation state and the query beside it
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[g]     <= xb;
                y_reg[g]     <= yb;
                z_reg[g]     <= zb;
                quad_reg[g]  <= qi;
                query_reg[g] <= di;
            end
        end
    end

    logic                                  valid_rnd_reg;
    logic signed [rrco_pkg::TRIG_W-1:0]    cos_reg, cos_next;
    logic signed [rrco_pkg::TRIG_W-1:0]    sin_reg, sin_next;
    rrco_pkg::query_t                      query_rnd_reg;
    logic signed [CW-1:0]                  x_rnd, y_rnd;
    logic signed [rrco_pkg::TRIG_W-1:0]    c0, s0;

    // Round to Q1.15, saturate, then apply the quadrant
    always_comb
    begin
        x_rnd = (x_reg[NS-1] + CW'(rrco_pkg::TRIG_HALF)) >>> rrco_pkg::TRIG_SHIFT;
        y_rnd = (y_reg[NS-1] + CW'(rrco_pkg::TRIG_HALF)) >>> rrco_pkg::TRIG_SHIFT;
        if (x_rnd > CW'(rrco_pkg::TRIG_MAX))
            c0 = rrco_pkg::TRIG_W'(rrco_pkg::TRIG_MAX);
        else if (x_rnd < -CW'(rrco_pkg::TRIG_MAX))
            c0 = -rrco_pkg::TRIG_W'(rrco_pkg::TRIG_MAX);
        else
            c0 = x_rnd[rrco_pkg::TRIG_W-1:0];
        if (y_rnd > CW'(rrco_pkg::TRIG_MAX))
            s0 = rrco_pkg::TRIG_W'(rrco_pkg::TRIG_MAX);
        else if (y_rnd < -CW'(rrco_pkg::TRIG_MAX))
            s0 = -rrco_pkg::TRIG_W'(rrco_pkg::TRIG_MAX);
        else
            s0 = y_rnd[rrco_pkg::TRIG_W-1:0];
        case (quad_reg[NS-1])
            rrco_pkg::QUAD_0:
            begin
                cos_next = c0;
                sin_next = s0;
            end
            rrco_pkg::QUAD_90:
            begin
                cos_next = -s0;
                sin_next = c0;
            end
            rrco_pkg::QUAD_180:
            begin
                cos_next = -c0;
                sin_next = -s0;
            end
            default:
            begin
                cos_next = s0;
                sin_next = -c0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_rnd_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_rnd_reg <= valid_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg       <= cos_next;
            sin_reg       <= sin_next;
            query_rnd_reg <= query_reg[NS-1];
        end
    end

    assign out_valid = valid_rnd_reg;
    assign cos_q15   = cos_reg;
    assign sin_q15   = sin_reg;
    assign out_query = query_rnd_reg;

endmodule

// File: rtl/core/rrco_rotate.sv
module rrco_rotate (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [rrco_pkg::TRIG_W-1:0] cos_q15,
    input  logic signed [rrco_pkg::TRIG_W-1:0] sin_q15,
    input  rrco_pkg::query_t                   in_query,
    output logic                               out_valid,
    output rrco_pkg::point_t                   out_point
);

    localparam int PW = rrco_pkg::PROD_W;
    localparam int SW = rrco_pkg::SUM_W;

    logic                  valid_mul_reg;
    logic signed [PW-1:0]  cd0_reg, sd1_reg, cd1_reg, sd0_reg;
    logic [rrco_pkg::EXT_W-1:0] hw_mul_reg, hd_mul_reg, r_mul_reg;

    logic                  valid_sum_reg;
    rrco_pkg::point_t      point_reg, point_next;
    logic signed [SW-1:0]  sum0, sum1, sh0, sh1;

    // Form the four products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_mul_reg <= 1'b0;
            valid_sum_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_mul_reg <= in_valid;
            valid_sum_reg <= valid_mul_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cd0_reg    <= PW'(cos_q15) * PW'(in_query.d0);
            sd1_reg    <= PW'(sin_q15) * PW'(in_query.d1);
            cd1_reg    <= PW'(cos_q15) * PW'(in_query.d1);
            sd0_reg    <= PW'(sin_q15) * PW'(in_query.d0);
            hw_mul_reg <= in_query.hw;
            hd_mul_reg <= in_query.hd;
            r_mul_reg  <= in_query.r;
        end
    end

    // Combine and round back to the coordinate grid
    always_comb
    begin
        sum0 = SW'(cd0_reg) - SW'(sd1_reg) + SW'(rrco_pkg::TRIG_HALF);
        sum1 = SW'(cd1_reg) + SW'(sd0_reg) + SW'(rrco_pkg::TRIG_HALF);
        sh0  = sum0 >>> rrco_pkg::TRIG_SHIFT;
        sh1  = sum1 >>> rrco_pkg::TRIG_SHIFT;
        point_next.p0 = sh0[rrco_pkg::P_W-1:0];
        point_next.p1 = sh1[rrco_pkg::P_W-1:0];
        point_next.hw = hw_mul_reg;
        point_next.hd = hd_mul_reg;
        point_next.r  = r_mul_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            point_reg <= point_next;
        end
    end

    assign out_valid = valid_sum_reg;
    assign out_point = point_reg;

endmodule

// File: rtl/core/rrco_region.sv
module rrco_region (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  rrco_pkg::point_t in_point,
    output logic             out_valid,
    output logic             overlap
);

    localparam int PW = rrco_pkg::P_W;
    localparam int EW = rrco_pkg::E_W;
    localparam int XW = rrco_pkg::EXT_W;
    localparam int QW = rrco_pkg::SQ_W;

    // Stage valid bits: abs, edge distance, squares, result
    logic valid_abs_reg, valid_ex_reg, valid_sq_reg, valid_hit_reg;

    logic [PW-1:0]          a0_reg, a1_reg;
    logic [XW-1:0]          hw_abs_reg, hd_abs_reg, r_abs_reg;

    logic signed [EW-1:0]   ex_reg, ey_reg, ex_next, ey_next;
    logic [XW-1:0]          r_ex_reg;

    logic                   outx_reg, outy_reg, ltx_reg, lty_reg;
    logic [QW-1:0]          sqx_reg, sqy_reg, sqr_reg;
    logic signed [EW-1:0]   r_ext;

    logic                   hit_reg, hit_next;
    logic [QW:0]            sq_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_abs_reg <= 1'b0;
            valid_ex_reg  <= 1'b0;
            valid_sq_reg  <= 1'b0;
            valid_hit_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_abs_reg <= in_valid;
            valid_ex_reg  <= valid_abs_reg;
            valid_sq_reg  <= valid_ex_reg;
            valid_hit_reg <= valid_sq_reg;
        end
    end

    // Fold the point into the first quadrant
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg     <= in_point.p0[PW-1] ? PW'(-in_point.p0) : PW'(in_point.p0);
            a1_reg     <= in_point.p1[PW-1] ? PW'(-in_point.p1) : PW'(in_point.p1);
            hw_abs_reg <= in_point.hw;
            hd_abs_reg <= in_point.hd;
            r_abs_reg  <= in_point.r;
        end
    end

    // Measure how far the point lies past each edge
    always_comb
    begin
        ex_next = $signed({1'b0, a0_reg}) - $signed({{(EW - XW){1'b0}}, hw_abs_reg});
        ey_next = $signed({1'b0, a1_reg}) - $signed({{(EW - XW){1'b0}}, hd_abs_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ex_reg   <= ex_next;
            ey_reg   <= ey_next;
            r_ex_reg <= r_abs_reg;
        end
    end

    // Classify the region and square the corner distances
    assign r_ext = $signed({{(EW - XW){1'b0}}, r_ex_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            outx_reg <= !ex_reg[EW-1] && (ex_reg != '0);
            outy_reg <= !ey_reg[EW-1] && (ey_reg != '0);
            ltx_reg  <= ex_reg < r_ext;
            lty_reg  <= ey_reg < r_ext;
            sqx_reg  <= QW'(ex_reg[XW-1:0]) * QW'(ex_reg[XW-1:0]);
            sqy_reg  <= QW'(ey_reg[XW-1:0]) * QW'(ey_reg[XW-1:0]);
            sqr_reg  <= QW'(r_ex_reg) * QW'(r_ex_reg);
        end
    end

    // Decide the hit by region
    always_comb
    begin
        sq_sum = (QW + 1)'(sqx_reg) + (QW + 1)'(sqy_reg);
        if (outx_reg && outy_reg)
            hit_next = ltx_reg && lty_reg && (sq_sum < (QW + 1)'(sqr_reg));
        else if (outx_reg)
            hit_next = ltx_reg;
        else if (outy_reg)
            hit_next = lty_reg;
        else
            hit_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hit_next;
        end
    end

    assign out_valid = valid_hit_reg;
    assign overlap   = hit_reg;

endmodule

// File: rtl/core/rotated_rect_circle_overlap.sv
// Throughput: one query per cycle while the output is not stalled; the 18-step
// CORDIC runs two steps per stage over nine stages after an input register,
// followed by trig round, multiply, round, fold, edge, square and result stages.
// A stalled output freezes the whole pipeline and stalls the input.
// Reset (rst_n low, asynchronous) clears every stage valid bit; data is kept.
module rotated_rect_circle_overlap (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic signed [rrco_pkg::COORD_WIDTH-1:0]  rect_x,
    input  logic signed [rrco_pkg::COORD_WIDTH-1:0]  rect_y,
    input  logic [rrco_pkg::ANGLE_WIDTH-1:0]         heading,
    input  logic [rrco_pkg::EXT_W-1:0]               half_width,
    input  logic [rrco_pkg::EXT_W-1:0]               half_depth,
    input  logic signed [rrco_pkg::COORD_WIDTH-1:0]  circle_x,
    input  logic signed [rrco_pkg::COORD_WIDTH-1:0]  circle_y,
    input  logic [rrco_pkg::EXT_W-1:0]               radius,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic                                     overlap
);

    localparam int DW = rrco_pkg::DIFF_W;

    logic                                 en;
    logic                                 valid_in_reg;
    logic [rrco_pkg::ANGLE_WIDTH-1:0]     heading_reg;
    rrco_pkg::query_t                     query_reg, query_next;

    logic                                 trig_valid;
    logic signed [rrco_pkg::TRIG_W-1:0]   cos_q15, sin_q15;
    rrco_pkg::query_t                     trig_query;

    logic                                 rot_valid;
    rrco_pkg::point_t                     rot_point;

    // Hold every stage while a finished result waits
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // Take the offsets of the circle from the rectangle center
    always_comb
    begin
        query_next.d0 = DW'(circle_x) - DW'(rect_x);
        query_next.d1 = DW'(circle_y) - DW'(rect_y);
        query_next.hw = half_width;
        query_next.hd = half_depth;
        query_next.r  = radius;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_in_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_in_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            heading_reg <= heading;
            query_reg   <= query_next;
        end
    end

    rrco_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (valid_in_reg),
        .heading   (heading_reg),
        .in_query  (query_reg),
        .out_valid (trig_valid),
        .cos_q15   (cos_q15),
        .sin_q15   (sin_q15),
        .out_query (trig_query)
    );

    rrco_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (trig_valid),
        .cos_q15   (cos_q15),
        .sin_q15   (sin_q15),
        .in_query  (trig_query),
        .out_valid (rot_valid),
        .out_point (rot_point)
    );

    rrco_region u_region (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rot_valid),
        .in_point  (rot_point),
        .out_valid (out_valid),
        .overlap   (overlap)
    );

endmodule
